@@ rtl/twrsm_pkg.sv @@
// Package for the three-wire serial master: pin sequencer state, item and
// result types, register map constants. No dependencies.
package twrsm_pkg;

  localparam int unsigned HALF_W      = 16;
  localparam int unsigned CFG_AW      = 3;
  localparam int unsigned CFG_DW      = 32;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 16;

  localparam logic [HALF_W-1:0] HALF_RESET = 16'd50;
  localparam logic [HALF_W-1:0] HALF_MIN   = 16'd1;

  // register index, taken from paddr[CFG_AW-1:2]
  localparam logic [CFG_AW-3:0] REG_HALF_PERIOD = 1'b0;

  localparam logic [7:0] CMD_WRITE_MASK = 8'hFE;
  localparam logic [7:0] CMD_READ_FLAG  = 8'h01;
  localparam logic [3:0] BITS_PER_BYTE  = 4'd8;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_PRE       = 4'd1,
    PH_CMD_SETUP = 4'd2,
    PH_CMD_HIGH  = 4'd3,
    PH_DAT_SETUP = 4'd4,
    PH_DAT_HIGH  = 4'd5,
    PH_END       = 4'd6
  } phase_t;

  typedef struct packed {
    phase_t              phase;
    logic [3:0]          bit_index;
    logic [7:0]          tx_shift;
    logic [7:0]          rx_shift;
    logic [HALF_W-1:0]   wait_count;
    logic                is_read;
    logic                pin_ce;
    logic                pin_sclk;
    logic                pin_io;
    logic                pin_drive;
    logic [7:0]          data_hold;
    logic [7:0]          last_read;
  } state_t;

  typedef struct packed {
    logic       start_req;
    logic       opcode;
    logic [7:0] command_byte;
    logic [7:0] write_data;
    logic       io_in;
  } in_item_t;

  typedef struct packed {
    logic       chip_enable;
    logic       serial_clock;
    logic       io_out;
    logic       io_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
  } res_t;

endpackage

@@ rtl/twrsm_cfg.sv @@
// APB-style register block: half period register.
// Depends on twrsm_pkg.
module twrsm_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [twrsm_pkg::CFG_AW-1:0]     paddr,
  input  logic [twrsm_pkg::CFG_DW-1:0]     pwdata,
  output logic [twrsm_pkg::CFG_DW-1:0]     prdata,
  output logic                             pready,
  output logic [twrsm_pkg::HALF_W-1:0]     half_period
);

  logic [twrsm_pkg::HALF_W-1:0] half_r;
  logic [twrsm_pkg::HALF_W-1:0] half_nxt;
  logic                         hit;

  assign pready = 1'b1;
  assign hit    = (paddr[twrsm_pkg::CFG_AW-1:2] == twrsm_pkg::REG_HALF_PERIOD);

  always_comb begin
    half_nxt = half_r;
    if (psel && penable && pwrite && pready && hit) begin
      half_nxt = pwdata[twrsm_pkg::HALF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= twrsm_pkg::HALF_RESET;
    end else begin
      half_r <= half_nxt;
    end
  end

  assign prdata = hit ? {{(twrsm_pkg::CFG_DW - twrsm_pkg::HALF_W){1'b0}}, half_r}
                      : '0;
  assign half_period = half_r;

endmodule

@@ rtl/twrsm_step.sv @@
// Next-state and result logic for one tick of the pin sequencer.
// Depends on twrsm_pkg.
module twrsm_step (
  input  twrsm_pkg::state_t             cur,
  input  twrsm_pkg::in_item_t           item,
  input  logic [twrsm_pkg::HALF_W-1:0]  half_period,
  output twrsm_pkg::state_t             nxt,
  output twrsm_pkg::res_t               res
);

  logic [twrsm_pkg::HALF_W-1:0] half_eff;
  logic [twrsm_pkg::HALF_W-1:0] cnt;
  logic                         expired;
  logic                         done;
  logic [7:0]                   tx_sh;
  logic [3:0]                   bi;

  // zero half period behaves as one
  assign half_eff = (half_period == '0) ? twrsm_pkg::HALF_MIN : half_period;
  assign cnt      = (cur.wait_count != '0) ? cur.wait_count - 1'b1 : cur.wait_count;
  assign tx_sh    = {1'b0, cur.tx_shift[7:1]};
  assign bi       = cur.bit_index + 4'd1;

  always_comb begin
    nxt     = cur;
    done    = 1'b0;
    expired = 1'b0;
    if (cur.phase == twrsm_pkg::PH_IDLE) begin
      if (item.start_req) begin
        nxt.is_read   = item.opcode;
        nxt.tx_shift  = item.opcode ? (item.command_byte | twrsm_pkg::CMD_READ_FLAG)
                                    : (item.command_byte & twrsm_pkg::CMD_WRITE_MASK);
        nxt.data_hold = item.write_data;
        nxt.pin_ce    = 1'b0;
        nxt.pin_sclk  = 1'b0;
        nxt.phase     = twrsm_pkg::PH_PRE;
        nxt.wait_count = half_eff;
      end
    end else begin
      nxt.wait_count = cnt;
      expired        = (cnt == '0);
    end

    if (expired) begin
      case (cur.phase)
        twrsm_pkg::PH_PRE: begin
          nxt.pin_ce    = 1'b1;
          nxt.pin_drive = 1'b1;
          nxt.bit_index = '0;
          nxt.pin_io    = cur.tx_shift[0];
          nxt.phase     = twrsm_pkg::PH_CMD_SETUP;
        end
        twrsm_pkg::PH_CMD_SETUP: begin
          nxt.pin_sclk = 1'b1;
          nxt.phase    = twrsm_pkg::PH_CMD_HIGH;
        end
        twrsm_pkg::PH_DAT_SETUP: begin
          nxt.pin_sclk = 1'b1;
          nxt.phase    = twrsm_pkg::PH_DAT_HIGH;
        end
        twrsm_pkg::PH_CMD_HIGH: begin
          nxt.pin_sclk = 1'b0;
          nxt.tx_shift = tx_sh;
          if (bi < twrsm_pkg::BITS_PER_BYTE) begin
            nxt.bit_index = bi;
            nxt.pin_io    = tx_sh[0];
            nxt.phase     = twrsm_pkg::PH_CMD_SETUP;
          end else begin
            nxt.bit_index = '0;
            if (cur.is_read) begin
              // release IO, take first read bit
              nxt.pin_drive = 1'b0;
              nxt.rx_shift  = {item.io_in, cur.rx_shift[7:1]};
            end else begin
              nxt.tx_shift = cur.data_hold;
              nxt.pin_io   = cur.data_hold[0];
            end
            nxt.phase = twrsm_pkg::PH_DAT_SETUP;
          end
        end
        twrsm_pkg::PH_DAT_HIGH: begin
          nxt.pin_sclk  = 1'b0;
          nxt.tx_shift  = tx_sh;
          nxt.bit_index = bi;
          if (bi < twrsm_pkg::BITS_PER_BYTE) begin
            if (cur.is_read) begin
              nxt.rx_shift = {item.io_in, cur.rx_shift[7:1]};
            end else begin
              nxt.pin_io = tx_sh[0];
            end
            nxt.phase = twrsm_pkg::PH_DAT_SETUP;
          end else begin
            nxt.phase = twrsm_pkg::PH_END;
          end
        end
        default: begin
          // closing edge: SCLK high, CE low
          nxt.pin_sclk = 1'b1;
          nxt.pin_ce   = 1'b0;
          if (cur.is_read) begin
            nxt.last_read = cur.rx_shift;
          end
          done      = 1'b1;
          nxt.phase = twrsm_pkg::PH_IDLE;
        end
      endcase
      if (nxt.phase != twrsm_pkg::PH_IDLE) begin
        nxt.wait_count = half_eff;
      end
    end
  end

  always_comb begin
    res.chip_enable  = nxt.pin_ce;
    res.serial_clock = nxt.pin_sclk;
    res.io_out       = nxt.pin_drive & nxt.pin_io;
    res.io_drive     = nxt.pin_drive;
    res.busy_res     = (nxt.phase != twrsm_pkg::PH_IDLE);
    res.done_res     = done;
    res.read_data    = nxt.last_read;
  end

endmodule

@@ rtl/three_wire_rtc_serial_master_top.sv @@
// Top level of the three-wire serial master (CE, SCLK, IO; LSB first).
// Depends on twrsm_pkg, twrsm_cfg and twrsm_step.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-------------------------------
//  in_      | sink      | in_tvalid/in_tready   | in_tdata, in_tuser (opcode)
//  out_     | source    | out_tvalid/out_tready | out_tdata (pin levels, status)
//  cfg_     | APB slave | psel/penable/pready   | half_period_cycles at 0x0
//
// One beat in gives one beat out. A beat is held in the input register,
// then one tick of the sequencer runs and lands in the result register;
// one beat per cycle sustained while results are taken.
// A result that is held by out_tready low stops the sequencer; once the
// input register is also full, in_tready drops until the result is taken.
// Reset (rst_n low, synchronous): sequencer idle, pins low with IO driven,
// half period 50, both registers empty.
module three_wire_rtc_serial_master_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in_tdata: [0] start_req, [8:1] command_byte, [16:9] write_data,
  //           [17] io_in, [23:18] zero
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [twrsm_pkg::IN_TDATA_W-1:0]     in_tdata,
  // in_tuser: [0] opcode
  input  logic                                 in_tuser,
  // out_tdata: [0] chip_enable, [1] serial_clock, [2] io_out, [3] io_drive,
  //            [4] busy_res, [5] done_res, [13:6] read_data, [15:14] zero
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [twrsm_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [twrsm_pkg::CFG_AW-1:0]         cfg_paddr,
  input  logic [twrsm_pkg::CFG_DW-1:0]         cfg_pwdata,
  output logic [twrsm_pkg::CFG_DW-1:0]         cfg_prdata,
  output logic                                 cfg_pready
);

  logic [twrsm_pkg::HALF_W-1:0] half_period;

  twrsm_pkg::in_item_t in_r;
  twrsm_pkg::in_item_t in_nxt;
  logic                in_v_r;
  logic                in_v_nxt;

  twrsm_pkg::state_t   st_r;
  twrsm_pkg::state_t   st_nxt;
  twrsm_pkg::state_t   step_st;

  twrsm_pkg::res_t     res_r;
  twrsm_pkg::res_t     res_nxt;
  twrsm_pkg::res_t     step_res;
  logic                out_v_r;
  logic                out_v_nxt;

  logic                advance;
  logic                in_beat;

  twrsm_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (cfg_psel),
    .penable     (cfg_penable),
    .pwrite      (cfg_pwrite),
    .paddr       (cfg_paddr),
    .pwdata      (cfg_pwdata),
    .prdata      (cfg_prdata),
    .pready      (cfg_pready),
    .half_period (half_period)
  );

  twrsm_step u_step (
    .cur         (st_r),
    .item        (in_r),
    .half_period (half_period),
    .nxt         (step_st),
    .res         (step_res)
  );

  // one sequencer tick per advance
  assign advance   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || advance;
  assign in_beat   = in_tvalid && in_tready;

  always_comb begin
    in_nxt   = in_r;
    in_v_nxt = in_v_r;
    if (in_beat) begin
      in_nxt.start_req    = in_tdata[0];
      in_nxt.opcode       = in_tuser;
      in_nxt.command_byte = in_tdata[8:1];
      in_nxt.write_data   = in_tdata[16:9];
      in_nxt.io_in        = in_tdata[17];
      in_v_nxt            = 1'b1;
    end else if (advance) begin
      in_v_nxt = 1'b0;
    end
  end

  always_comb begin
    st_nxt    = st_r;
    res_nxt   = res_r;
    out_v_nxt = out_v_r;
    if (advance) begin
      st_nxt    = step_st;
      res_nxt   = step_res;
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      st_r    <= '{phase:     twrsm_pkg::PH_IDLE,
                   bit_index: '0,
                   tx_shift:  '0,
                   rx_shift:  '0,
                   wait_count: '0,
                   is_read:   1'b0,
                   pin_ce:    1'b0,
                   pin_sclk:  1'b0,
                   pin_io:    1'b0,
                   pin_drive: 1'b1,
                   data_hold: '0,
                   last_read: '0};
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
      st_r    <= st_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    in_r  <= in_nxt;
    res_r <= res_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00,
                       res_r.read_data,
                       res_r.done_res,
                       res_r.busy_res,
                       res_r.io_drive,
                       res_r.io_out,
                       res_r.serial_clock,
                       res_r.chip_enable};

`ifndef SYNTHESIS
  // a busy sequencer always has a wait pending
  a_wait_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase != twrsm_pkg::PH_IDLE) |-> (st_r.wait_count != '0))
    else $error("busy sequencer with zero wait count");

  // CE stays high through command and data bits
  a_ce_in_bits: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase == twrsm_pkg::PH_CMD_SETUP || st_r.phase == twrsm_pkg::PH_CMD_HIGH ||
     st_r.phase == twrsm_pkg::PH_DAT_SETUP || st_r.phase == twrsm_pkg::PH_DAT_HIGH)
    |-> st_r.pin_ce)
    else $error("CE low during bit transfer");

  // IO is always driven while the command byte goes out
  a_drive_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase == twrsm_pkg::PH_CMD_SETUP || st_r.phase == twrsm_pkg::PH_CMD_HIGH)
    |-> st_r.pin_drive)
    else $error("IO released during command byte");

  // done result beats are never marked busy
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && res_r.done_res) |-> !res_r.busy_res)
    else $error("done result with busy set");
`endif

endmodule
